@@ rtl/rebc_pkg.sv @@
// Package for the random-eviction byte-budget cache.
// Widths, result kinds, sequencer states and the LFSR step; no dependencies.
`default_nettype none
package rebc_pkg;
   localparam int KeyWidth    = 64;
   localparam int HandleWidth = 32;
   localparam int SizeWidth   = 24;
   localparam int TotalWidth  = 25;
   localparam int LfsrWidth   = 16;
   localparam int DefaultEntries = 32;
   localparam logic [SizeWidth-1:0] CapacityReset = 24'd1048576;
   localparam logic [LfsrWidth-1:0] LfsrSeed = 16'hACE1;
   localparam logic [LfsrWidth-1:0] LfsrTaps = 16'hB400;

   localparam logic OpLookup = 1'b0;
   localparam logic OpInsert = 1'b1;

   typedef enum logic [2:0] {
      KIND_HIT      = 3'd0,
      KIND_MISS     = 3'd1,
      KIND_EVICTED  = 3'd2,
      KIND_INSERTED = 3'd3,
      KIND_TOO_BIG  = 3'd4,
      KIND_DUP      = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_MOD,
      ST_VIC_RD,
      ST_VIC_WAIT,
      ST_LAST_RD,
      ST_LAST_WAIT,
      ST_EMIT,
      ST_STORE,
      ST_FINAL
   } state_type;

   function automatic logic [LfsrWidth-1:0] lfsr_next(input logic [LfsrWidth-1:0] s);
      logic [LfsrWidth-1:0] r;
      r = s >> 1;
      if (s[0]) r = r ^ LfsrTaps;
      return r;
   endfunction
endpackage
`default_nettype wire

@@ rtl/rebc_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on rebc_pkg for field widths.
`default_nettype none
interface rebc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [rebc_pkg::KeyWidth-1:0]    key;
   logic [rebc_pkg::SizeWidth-1:0]   item_size;
   logic [rebc_pkg::HandleWidth-1:0] handle;
   modport source (output valid, operation, key, item_size, handle, input ready);
   modport sink   (input valid, operation, key, item_size, handle, output ready);
endinterface

interface rebc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     kind;
   logic [rebc_pkg::KeyWidth-1:0]    key_out;
   logic [rebc_pkg::HandleWidth-1:0] handle_out;
   logic [rebc_pkg::TotalWidth-1:0]  occupied_bytes;
   logic                           last;
   modport source (output valid, kind, key_out, handle_out, occupied_bytes, last,
                   input ready);
   modport sink   (input valid, kind, key_out, handle_out, occupied_bytes, last,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/rebc_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rebc_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/random_evict_byte_budget_cache_unit.sv @@
// Random-eviction byte-budget cache: top level and sequencer.
// Depends on rebc_pkg, rebc_if and rebc_ram.
//
// A request beat carries operation, key, item_size and handle. Lookup scans
// the stored entries one by one from a single memory holding key, handle
// and size, and answers hit or miss with one response beat.
// Insert scans the same way for a duplicate; a duplicate or an item above
// the capacity gets one beat marked last. Otherwise, while over budget or
// full, it evicts random victims: each eviction steps the LFSR, reduces it
// modulo the entry count with a bit-serial remainder, reads victim and last
// entry, sends an evicted beat and moves the last entry into the victim
// slot. The insert ends with an inserted beat marked last.
// One request is in flight at a time; req.ready is high only when idle, so
// the next request is taken at the earliest in the cycle its predecessor's
// last beat is offered.
// Reset clears count and total, reseeds the LFSR and restores the default
// capacity; the memory holds no reset.
// A stalled response holds its beat and the sequencer waits with it.
`default_nettype none
module random_evict_byte_budget_cache_unit #(
   parameter int ENTRIES = rebc_pkg::DefaultEntries
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wr_en,
   input  wire logic [rebc_pkg::SizeWidth-1:0] csr_wr_data,
   rebc_req_if.sink   req,
   rebc_rsp_if.source rsp
);
   localparam int IdxW = $clog2(ENTRIES);
   localparam int CntW = $clog2(ENTRIES + 1);
   localparam int KW = rebc_pkg::KeyWidth;
   localparam int HW = rebc_pkg::HandleWidth;
   localparam int SW = rebc_pkg::SizeWidth;
   localparam int TW = rebc_pkg::TotalWidth;
   localparam int LW = rebc_pkg::LfsrWidth;
   localparam int MW = KW + HW + SW;
   localparam logic [CntW-1:0] Full = CntW'(ENTRIES);

   rebc_pkg::state_type state_ff, state_in;
   logic [SW-1:0] cap_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [TW-1:0] total_ff, total_in;
   logic [LW-1:0] lfsr_ff, lfsr_in;
   logic op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] size_ff, size_in;
   logic [HW-1:0] hdl_ff, hdl_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] vic_ff, vic_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [4:0] bit_ff, bit_in;
   logic [MW-1:0] vdata_ff, vdata_in;
   logic found_ff, found_in;
   logic [HW-1:0] fhdl_ff, fhdl_in;
   logic ov_ff, ov_in;
   rebc_pkg::kind_type okind_ff, okind_in;
   logic [KW-1:0] okey_ff, okey_in;
   logic [HW-1:0] ohdl_ff, ohdl_in;
   logic olast_ff, olast_in;

   logic we;
   logic [IdxW-1:0] wa, ra;
   logic [MW-1:0] wd, rd;

   rebc_ram #(.Width(MW), .Depth(ENTRIES)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd));

   logic [LW:0] trial;
   logic [LW-1:0] lnext;

   always_comb begin
      state_in = state_ff; count_in = count_ff; total_in = total_ff;
      lfsr_in = lfsr_ff; op_in = op_ff; key_in = key_ff; size_in = size_ff;
      hdl_in = hdl_ff; idx_in = idx_ff; vic_in = vic_ff; rem_in = rem_ff;
      bit_in = bit_ff; vdata_in = vdata_ff; found_in = found_ff;
      fhdl_in = fhdl_ff; ov_in = ov_ff; okind_in = okind_ff; okey_in = okey_ff;
      ohdl_in = ohdl_ff; olast_in = olast_ff;
      we = 1'b0; wa = '0; wd = '0; ra = idx_ff[IdxW-1:0];
      lnext = rebc_pkg::lfsr_next(lfsr_ff);
      trial = {rem_ff, lfsr_ff[4'(LW-1) - bit_ff[3:0]]} - {(LW+1-CntW)'(0), count_ff};
      req.ready = (state_ff == rebc_pkg::ST_IDLE);
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      unique case (state_ff)
         rebc_pkg::ST_IDLE: begin
            if (req.valid) begin
               op_in = req.operation; key_in = req.key; size_in = req.item_size;
               hdl_in = req.handle; idx_in = '0; found_in = 1'b0;
               state_in = rebc_pkg::ST_SCAN_RD;
            end
         end
         rebc_pkg::ST_SCAN_RD: begin
            if (idx_ff >= count_ff) state_in = rebc_pkg::ST_DECIDE;
            else state_in = rebc_pkg::ST_SCAN_CMP;
         end
         rebc_pkg::ST_SCAN_CMP: begin
            if (rd[MW-1 -: KW] == key_ff) begin
               found_in = 1'b1; fhdl_in = rd[SW +: HW];
               state_in = rebc_pkg::ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = rebc_pkg::ST_SCAN_RD;
            end
         end
         rebc_pkg::ST_DECIDE: begin
            if (!ov_ff || rsp.ready) begin
               if (op_ff == rebc_pkg::OpLookup) begin
                  ov_in = 1'b1; olast_in = 1'b1;
                  okind_in = found_ff ? rebc_pkg::KIND_HIT : rebc_pkg::KIND_MISS;
                  okey_in = found_ff ? key_ff : '0;
                  ohdl_in = found_ff ? fhdl_ff : '0;
                  state_in = rebc_pkg::ST_IDLE;
               end else if (size_ff > cap_ff || found_ff) begin
                  ov_in = 1'b1; olast_in = 1'b1; okey_in = '0; ohdl_in = '0;
                  okind_in = (size_ff > cap_ff) ? rebc_pkg::KIND_TOO_BIG
                                                : rebc_pkg::KIND_DUP;
                  state_in = rebc_pkg::ST_IDLE;
               end else begin
                  total_in = total_ff + TW'(size_ff);
                  state_in = rebc_pkg::ST_EMIT;
                  olast_in = 1'b0;
               end
            end
         end
         rebc_pkg::ST_EMIT: begin
            // loop head: evict or store
            if ((total_ff > TW'(cap_ff) || count_ff >= Full) && count_ff != '0) begin
               lfsr_in = lnext; rem_in = '0; bit_in = '0;
               state_in = rebc_pkg::ST_MOD;
            end else state_in = rebc_pkg::ST_STORE;
         end
         rebc_pkg::ST_MOD: begin
            if (!trial[LW]) rem_in = trial[LW-1:0];
            else rem_in = {rem_ff[LW-2:0], lfsr_ff[4'(LW-1) - bit_ff[3:0]]};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 5'(LW-1)) state_in = rebc_pkg::ST_VIC_RD;
         end
         rebc_pkg::ST_VIC_RD: begin
            vic_in = rem_ff[IdxW-1:0];
            ra = rem_ff[IdxW-1:0];
            state_in = rebc_pkg::ST_VIC_WAIT;
         end
         rebc_pkg::ST_VIC_WAIT: begin
            vdata_in = rd;
            ra = IdxW'(count_ff - 1'b1);
            state_in = rebc_pkg::ST_LAST_RD;
         end
         rebc_pkg::ST_LAST_RD: begin
            ra = IdxW'(count_ff - 1'b1);
            if (!ov_ff || rsp.ready) begin
               // move last entry into the victim slot and send evicted beat
               we = 1'b1; wa = vic_ff; wd = rd;
               total_in = total_ff - TW'(vdata_ff[SW-1:0]);
               count_in = count_ff - 1'b1;
               ov_in = 1'b1; olast_in = 1'b0; okind_in = rebc_pkg::KIND_EVICTED;
               okey_in = vdata_ff[MW-1 -: KW]; ohdl_in = vdata_ff[SW +: HW];
               state_in = rebc_pkg::ST_LAST_WAIT;
            end
         end
         rebc_pkg::ST_LAST_WAIT: state_in = rebc_pkg::ST_EMIT;
         rebc_pkg::ST_STORE: begin
            if (count_ff < Full) begin
               we = 1'b1; wa = IdxW'(count_ff); wd = {key_ff, hdl_ff, size_ff};
               count_in = count_ff + 1'b1;
            end
            state_in = rebc_pkg::ST_FINAL;
         end
         rebc_pkg::ST_FINAL: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; olast_in = 1'b1; okind_in = rebc_pkg::KIND_INSERTED;
               okey_in = key_ff; ohdl_in = '0;
               state_in = rebc_pkg::ST_IDLE;
            end
         end
         default: state_in = rebc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rebc_pkg::ST_IDLE; cap_ff <= rebc_pkg::CapacityReset;
         count_ff <= '0; total_ff <= '0; lfsr_ff <= rebc_pkg::LfsrSeed;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; total_ff <= total_in;
         lfsr_ff <= lfsr_in; ov_ff <= ov_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
      op_ff <= op_in; key_ff <= key_in; size_ff <= size_in; hdl_ff <= hdl_in;
      idx_ff <= idx_in; vic_ff <= vic_in; rem_ff <= rem_in; bit_ff <= bit_in;
      vdata_ff <= vdata_in; found_ff <= found_in; fhdl_ff <= fhdl_in;
      okind_ff <= okind_in; okey_ff <= okey_in; ohdl_ff <= ohdl_in;
      olast_ff <= olast_in;
   end

   logic [TW-1:0] obytes_ff;
   always_ff @(posedge clock) begin
      if (ov_in && (!ov_ff || rsp.ready)) obytes_ff <= total_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.kind = okind_ff;
   assign rsp.key_out = okey_ff;
   assign rsp.handle_out = ohdl_ff;
   assign rsp.occupied_bytes = obytes_ff;
   assign rsp.last = olast_ff;
endmodule
`default_nettype wire

@@ rtl/rebc_checker.sv @@
// Port-level checks for the cache unit, bound to the top level.
// Depends on rebc_pkg and the top-level port names.
`default_nettype none
module rebc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic rsp_last
);
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind <= 3'(rebc_pkg::KIND_DUP))) else $error("bad kind");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'(rebc_pkg::KIND_EVICTED) |-> !rsp_last)
      else $error("evicted beat marked last");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accepted while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled beat dropped");
endmodule

bind random_evict_byte_budget_cache_unit rebc_checker u_rebc_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.kind),
   .rsp_last(rsp.last));
`default_nettype wire

@@ tb/sv/random_evict_byte_budget_cache_unit_tb.sv @@
// Testbench for the random-eviction byte-budget cache unit.
// Drives request beats through a table and random traffic, predicts every
// response beat in a behavioral cache model; depends on rebc_pkg and rebc_if.
module random_evict_byte_budget_cache_unit_tb;

   localparam int Entries = rebc_pkg::DefaultEntries;
   localparam int KW = rebc_pkg::KeyWidth;
   localparam int HW = rebc_pkg::HandleWidth;
   localparam int SW = rebc_pkg::SizeWidth;
   localparam int TW = rebc_pkg::TotalWidth;
   localparam int LW = rebc_pkg::LfsrWidth;

   typedef struct packed {
      logic          operation;
      logic [KW-1:0] key;
      logic [SW-1:0] item_size;
      logic [HW-1:0] handle;
   } req_beat_type;

   typedef struct packed {
      rebc_pkg::kind_type kind;
      logic [KW-1:0]      key_out;
      logic [HW-1:0]      handle_out;
      logic [TW-1:0]      occupied_bytes;
      logic               last;
   } rsp_beat_type;

   // directed row: has_check set when the expected beat is typed in
   typedef struct {
      req_beat_type beat;
      logic         has_check;
      rsp_beat_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [SW-1:0] csr_wr_data = '0;

   rebc_req_if req ();
   rebc_rsp_if rsp ();

   random_evict_byte_budget_cache_unit #(.ENTRIES(Entries)) u_dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .req(req), .rsp(rsp)
   );

   always #5 clock = ~clock;

   // shadow cache state
   logic [KW-1:0] sh_keys [Entries];
   logic [HW-1:0] sh_handles [Entries];
   logic [SW-1:0] sh_sizes [Entries];
   int unsigned   sh_count;
   logic [TW-1:0] sh_total;
   logic [LW-1:0] sh_lfsr;
   logic [SW-1:0] sh_capacity;

   rsp_beat_type pending_rsp[$];
   int  mismatches = 0;
   bit  rx_idle_on = 1'b1;
   bit  tx_idle_on = 1'b1;
   int  hold_rx = 0;

   function automatic rsp_beat_type mk_rsp(rebc_pkg::kind_type k, logic [KW-1:0] key,
                                           logic [HW-1:0] h, logic l);
      rsp_beat_type r;
      r.kind = k; r.key_out = key; r.handle_out = h;
      r.occupied_bytes = sh_total; r.last = l;
      return r;
   endfunction

   function automatic void queue_rsp(rsp_beat_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function automatic int find_key(logic [KW-1:0] key);
      for (int i = 0; i < sh_count; i++)
         if (sh_keys[i] == key) return i;
      return -1;
   endfunction

   // queue the response beats this request causes, in order
   task automatic predict_cache(req_beat_type b);
      int pos;
      int unsigned v, li;
      pos = find_key(b.key);
      if (b.operation == rebc_pkg::OpLookup) begin
         if (pos >= 0)
            queue_rsp(mk_rsp(rebc_pkg::KIND_HIT, b.key, sh_handles[pos], 1'b1));
         else
            queue_rsp(mk_rsp(rebc_pkg::KIND_MISS, '0, '0, 1'b1));
         return;
      end
      if (b.item_size > sh_capacity) begin
         queue_rsp(mk_rsp(rebc_pkg::KIND_TOO_BIG, '0, '0, 1'b1));
         return;
      end
      if (pos >= 0) begin
         queue_rsp(mk_rsp(rebc_pkg::KIND_DUP, '0, '0, 1'b1));
         return;
      end
      sh_total = sh_total + TW'(b.item_size);
      while ((sh_total > TW'(sh_capacity) || sh_count >= Entries) && sh_count > 0) begin
         sh_lfsr = rebc_pkg::lfsr_next(sh_lfsr);
         v = sh_lfsr % sh_count;
         li = sh_count - 1;
         sh_total = sh_total - TW'(sh_sizes[v]);
         queue_rsp(mk_rsp(rebc_pkg::KIND_EVICTED, sh_keys[v], sh_handles[v], 1'b0));
         sh_keys[v] = sh_keys[li];
         sh_handles[v] = sh_handles[li];
         sh_sizes[v] = sh_sizes[li];
         sh_count = li;
      end
      if (sh_count < Entries) begin
         sh_keys[sh_count] = b.key;
         sh_handles[sh_count] = b.handle;
         sh_sizes[sh_count] = b.item_size;
         sh_count++;
      end
      queue_rsp(mk_rsp(rebc_pkg::KIND_INSERTED, b.key, '0, 1'b1));
   endtask

   task automatic note_mismatch(rsp_beat_type want, rsp_beat_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: want kind %0d key %h handle %h bytes %0d last %0d",
                  want.kind, want.key_out, want.handle_out, want.occupied_bytes,
                  want.last);
         $display("          got  kind %0d key %h handle %h bytes %0d last %0d",
                  got.kind, got.key_out, got.handle_out, got.occupied_bytes, got.last);
      end
   endtask

   // response side: random idling plus commanded long hold
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            rsp.ready <= 1'b0;
         end else
            rsp.ready <= !(rx_idle_on && $urandom_range(99) < 32);
      end
   end

   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind = rebc_pkg::kind_type'(rsp.kind); got.key_out = rsp.key_out;
         got.handle_out = rsp.handle_out; got.occupied_bytes = rsp.occupied_bytes;
         got.last = rsp.last;
         if (pending_rsp.size() == 0) begin
            want = '0;
            note_mismatch(want, got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) note_mismatch(want, got);
         end
      end
   end

   // hold valid low while idling; valid stays high between back-to-back beats
   task automatic send_beat(req_beat_type b);
      while (tx_idle_on && $urandom_range(99) < 32) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= b.operation; req.key <= b.key;
      req.item_size <= b.item_size; req.handle <= b.handle;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_cache(b);
   endtask

   task automatic drain_then_settle();
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_capacity(logic [SW-1:0] cap);
      drain_then_settle();
      csr_wr_en <= 1'b1; csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sh_capacity = cap;
   endtask

   function automatic req_beat_type mk_req(logic op, logic [KW-1:0] k,
                                           logic [SW-1:0] s, logic [HW-1:0] h);
      req_beat_type b;
      b.operation = op; b.key = k; b.item_size = s; b.handle = h;
      return b;
   endfunction

   function automatic logic [KW-1:0] pick_key(int pool);
      if ($urandom_range(9) == 0) return {$urandom, $urandom};
      return 64'h5A00_0000_0000_0000 | 64'($urandom_range(pool - 1));
   endfunction

   dir_row_type dir_rows[$];

   task automatic add_row(req_beat_type b, logic chk, rsp_beat_type w);
      dir_row_type r;
      r.beat = b; r.has_check = chk; r.want = w;
      dir_rows.insert(dir_rows.size(), r);
   endtask

   initial begin
      req_beat_type b;
      rsp_beat_type w;
      int n;
      req.valid = 1'b0; req.operation = rebc_pkg::OpLookup; req.key = '0;
      req.item_size = '0; req.handle = '0;
      sh_count = 0; sh_total = '0; sh_lfsr = rebc_pkg::LfsrSeed;
      sh_capacity = rebc_pkg::CapacityReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      w = '0;
      w.kind = rebc_pkg::KIND_MISS; w.last = 1'b1;
      add_row(mk_req(rebc_pkg::OpLookup, '1, '1, '1), 1'b1, w);
      w.kind = rebc_pkg::KIND_TOO_BIG;
      add_row(mk_req(rebc_pkg::OpInsert, 64'h1, 24'hFFFFFF, 32'h1), 1'b1, w);
      w.kind = rebc_pkg::KIND_INSERTED; w.key_out = '1;
      add_row(mk_req(rebc_pkg::OpInsert, '1, 24'd0, '1), 1'b1, w);
      w.kind = rebc_pkg::KIND_HIT; w.handle_out = '1;
      add_row(mk_req(rebc_pkg::OpLookup, '1, '0, '0), 1'b1, w);
      w = '0; w.kind = rebc_pkg::KIND_DUP; w.last = 1'b1;
      add_row(mk_req(rebc_pkg::OpInsert, '1, 24'd5, 32'h0), 1'b1, w);
      w = '0; w.kind = rebc_pkg::KIND_INSERTED; w.key_out = '0;
      w.occupied_bytes = 25'd1048576; w.last = 1'b1;
      add_row(mk_req(rebc_pkg::OpInsert, '0, 24'd1048576, '0), 1'b1, w);
      // over budget: evicts to make room
      add_row(mk_req(rebc_pkg::OpInsert, 64'h77, 24'd524288, 32'hA5A5_5A5A), 1'b0, w);
      add_row(mk_req(rebc_pkg::OpLookup, '0, '0, '0), 1'b0, w);
      // fill the table so the full-table eviction shows up
      for (int i = 0; i < Entries + 2; i++)
         add_row(mk_req(rebc_pkg::OpInsert, 64'hF000 + 64'(i), 24'd1,
                        32'hC000 + 32'(i)), 1'b0, w);
      for (int i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].has_check) begin
            drain_then_settle();
            w = dir_rows[i].want;
            w.occupied_bytes = (w.kind == rebc_pkg::KIND_INSERTED &&
                                dir_rows[i].beat.key == '1) ? sh_total : w.occupied_bytes;
            if (w.kind != rebc_pkg::KIND_INSERTED) w.occupied_bytes = sh_total;
            send_beat(dir_rows[i].beat);
            if (pending_rsp.size() != 1 || pending_rsp[0] !== w)
               note_mismatch(w, pending_rsp[0]);
         end else
            send_beat(dir_rows[i].beat);
      end

      // lowered capacity forces a long eviction run, then extremes
      set_capacity(24'd0);
      send_beat(mk_req(rebc_pkg::OpInsert, 64'h9, 24'd0, 32'h9));
      set_capacity(24'hFFFFFF);
      send_beat(mk_req(rebc_pkg::OpInsert, 64'hA, 24'hFFFFFF, 32'hA));

      // block fills while the receiver holds off
      hold_rx = 300;
      for (int i = 0; i < 6; i++)
         send_beat(mk_req(rebc_pkg::OpLookup, pick_key(40), '0, '0));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_capacity(24'd3000);
            1: set_capacity(24'd20000);
            2: set_capacity(24'd1);
            default: set_capacity(rebc_pkg::CapacityReset);
         endcase
         tx_idle_on = (phase != 1);
         rx_idle_on = (phase != 1);
         for (n = 0; n < 75; n++) begin
            b.operation = 1'($urandom_range(1));
            b.key = pick_key(48);
            case ($urandom_range(9))
               0: b.item_size = SW'($urandom);
               1: b.item_size = '0;
               default: b.item_size = SW'($urandom_range(1200));
            endcase
            b.handle = $urandom;
            send_beat(b);
            if (n == 40) drain_then_settle();
         end
      end
      tx_idle_on = 1'b1; rx_idle_on = 1'b1;
      drain_then_settle();
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("random_evict_byte_budget_cache_unit test passed");
      else
         $display("random_evict_byte_budget_cache_unit test failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("random_evict_byte_budget_cache_unit test failed");
      $finish;
   end
endmodule
